// File: rtl/core/sst_pkg.sv
package sst_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int FUNC_W      = 2;
    localparam int IN_VALUE_W  = 32;
    localparam int OUT_COUNT_W = 5;
    localparam int OUT_VALUE_W = 32;

    localparam int IN_BITS    = FUNC_W + IN_VALUE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + 1 + OUT_COUNT_W + 1 + OUT_VALUE_W + OUT_VALUE_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [WIDTH-1:0] t_val;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_CLEAR    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_CLEAR
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        t_val      key;
    } t_cell_ctl;

    typedef struct packed {
        logic any_eq;
        logic full;
        logic nonempty;
        t_val min_val;
        t_val max_val;
    } t_chain_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/sorted_set_table_top.sv
// Sorted value table: up to 16 signed 32-bit entries kept in ascending order in a
// row of cells, duplicates allowed. Each input transfer carries an operation
// (insert, remove all equal, contains, clear) and yields exactly one result
// transfer with found/accepted flags, the entry count, an empty flag and the
// smallest and largest entries (zero, with extremes_valid low, when empty).
// One item is processed at a time: each item is taken in while idle, executed
// in the EXEC state and written out from the DONE state; remove stays in EXEC
// until no equal entry is left, because the cell row drops one entry per
// cycle. A finished result is held in the output register while the next
// item is taken in; that item then waits for the register to free up.
module sorted_set_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] func, [33:2] value, [39:34] zero
    input  logic [sst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] found, [1] accepted, [6:2] entry_count, [7] is_empty,
    // [39:8] min_value, [71:40] max_value, [72] extremes_valid, [79:73] zero
    output logic [sst_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import sst_pkg::*;

    t_state        r_state, n_state;
    t_func         r_func, n_func;
    t_val          r_key, n_key;
    t_cnt          r_count, n_count;
    logic          r_found, n_found;
    logic          r_accepted, n_accepted;
    logic          r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    t_cell_ctl     ctl;
    t_chain_status status;

    logic signed [IN_VALUE_W-1:0] in_value;
    logic          in_xfer;

    assign in_value = s_axis_tdata[FUNC_W +: IN_VALUE_W];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    sst_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .o_status (status)
    );

    always_comb begin
        logic signed [OUT_VALUE_W-1:0] min_o;
        logic signed [OUT_VALUE_W-1:0] max_o;
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_count     = r_count;
        n_found     = r_found;
        n_accepted  = r_accepted;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ctl.cmd     = CMD_HOLD;
        ctl.key     = r_key;
        min_o       = OUT_VALUE_W'(status.min_val);
        max_o       = OUT_VALUE_W'(status.max_val);

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_func     = t_func'(s_axis_tdata[FUNC_W-1:0]);
                    n_key      = WIDTH'(in_value);
                    n_found    = 1'b0;
                    n_accepted = 1'b0;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_func)
                    FUNC_INSERT: begin
                        if (!status.full) begin
                            ctl.cmd    = CMD_INSERT;
                            n_count    = r_count + 1'b1;
                            n_accepted = 1'b1;
                        end
                        n_state = ST_DONE;
                    end
                    FUNC_REMOVE: begin
                        // Repeat until no equal entry is left.
                        if (status.any_eq) begin
                            ctl.cmd = CMD_REMOVE;
                            n_count = r_count - 1'b1;
                            n_found = 1'b1;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    FUNC_CONTAINS: begin
                        n_found = status.any_eq;
                        n_state = ST_DONE;
                    end
                    FUNC_CLEAR: begin
                        ctl.cmd = CMD_CLEAR;
                        n_count = '0;
                        n_state = ST_DONE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({
                        status.nonempty,
                        max_o,
                        min_o,
                        !status.nonempty,
                        OUT_COUNT_W'(r_count),
                        r_accepted,
                        r_found
                    });
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_found    <= n_found;
        r_accepted <= n_accepted;
        r_out_data <= n_out_data;
    end

endmodule

// File: rtl/core/sst_cell.sv
module sst_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sst_pkg::t_cell_ctl i_ctl,
    input  logic             i_left_valid,
    input  sst_pkg::t_val    i_left_val,
    input  logic             i_left_gt,
    input  logic             i_right_valid,
    input  sst_pkg::t_val    i_right_val,
    output logic             o_valid,
    output sst_pkg::t_val    o_val,
    output logic             o_gt,
    output logic             o_eq
);
    import sst_pkg::*;

    logic r_valid, n_valid;
    t_val r_val, n_val;
    logic ge;

    // Empty slots count as greater than any key so inserts land there.
    assign o_gt    = !r_valid || (r_val > i_ctl.key);
    assign ge      = !r_valid || (r_val >= i_ctl.key);
    assign o_eq    = r_valid && (r_val == i_ctl.key);
    assign o_valid = r_valid;
    assign o_val   = r_val;

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        unique case (i_ctl.cmd)
            CMD_INSERT: begin
                if (i_left_gt) begin
                    n_valid = i_left_valid;
                    n_val   = i_left_val;
                end else if (o_gt) begin
                    n_valid = 1'b1;
                    n_val   = i_ctl.key;
                end
            end
            CMD_REMOVE: begin
                // Drop the first equal entry: everything from it on moves down one.
                if (ge) begin
                    n_valid = i_right_valid;
                    n_val   = i_right_val;
                end
            end
            CMD_CLEAR: n_valid = 1'b0;
            CMD_HOLD:  ;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: rtl/core/sst_chain.sv
module sst_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sst_pkg::t_cell_ctl    i_ctl,
    output sst_pkg::t_chain_status o_status
);
    import sst_pkg::*;

    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] eq;
    t_val             val [DEPTH];

    logic [DEPTH:0]   left_valid;
    logic [DEPTH:0]   left_gt;
    t_val             left_val [DEPTH+1];

    // Neighbor links; the ends see an empty, non-greater slot.
    assign left_valid[0] = 1'b0;
    assign left_gt[0]    = 1'b0;
    assign left_val[0]   = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic right_valid;
        t_val right_val;

        assign left_valid[g+1] = valid[g];
        assign left_gt[g+1]    = gt[g];
        assign left_val[g+1]   = val[g];

        if (g == DEPTH - 1) begin : g_end
            assign right_valid = 1'b0;
            assign right_val   = '0;
        end else begin : g_mid
            assign right_valid = valid[g+1];
            assign right_val   = val[g+1];
        end

        sst_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_left_valid  (left_valid[g]),
            .i_left_val    (left_val[g]),
            .i_left_gt     (left_gt[g]),
            .i_right_valid (right_valid),
            .i_right_val   (right_val),
            .o_valid       (valid[g]),
            .o_val         (val[g]),
            .o_gt          (gt[g]),
            .o_eq          (eq[g])
        );
    end

    always_comb begin
        t_val max_acc;
        logic last;
        max_acc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            // The last occupied slot carries the maximum.
            last    = valid[i] && ((i == DEPTH - 1) || !left_valid[(i + 2) % (DEPTH + 1)]);
            max_acc = max_acc | (val[i] & {WIDTH{last}});
        end
        o_status.any_eq   = |eq;
        o_status.full     = valid[DEPTH-1];
        o_status.nonempty = valid[0];
        o_status.min_val  = val[0] & {WIDTH{valid[0]}};
        o_status.max_val  = max_acc;
    end

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    typedef struct {
        bit        found;
        bit        accepted;
        bit [4:0]  count;
        bit        empty;
        bit [31:0] min_v;
        bit [31:0] max_v;
        bit        extremes_ok;
    } table_result_t;

    typedef struct {
        t_func         op;
        t_val          value;
        int            reps;
        bit            typed;
        table_result_t want;
    } table_step_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [1:0] func, [33:2] value, [39:34] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] found, [1] accepted, [6:2] entry_count, [7] is_empty,
    // [39:8] min_value, [71:40] max_value, [72] extremes_valid, [79:73] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the table
    t_val          shadow_entries [DEPTH];
    int            shadow_count = 0;
    table_result_t pending_results [$];
    table_step_t   directed_steps [$];
    int            errors = 0;
    bit            steady = 1'b0;
    bit            hold_req = 1'b0;
    int            stall_left = 0;

    sorted_set_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic apply_table_op(input t_func op, input t_val v, output table_result_t r);
        int pos;
        int j;
        r = '{default: 0};
        case (op)
            FUNC_INSERT: begin
                if (shadow_count < DEPTH) begin
                    pos = 0;
                    while (pos < shadow_count && shadow_entries[pos] <= v)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = v;
                    shadow_count++;
                    r.accepted = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                j = 0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_entries[i] == v)
                        r.found = 1'b1;
                    else begin
                        shadow_entries[j] = shadow_entries[i];
                        j++;
                    end
                end
                shadow_count = j;
            end
            FUNC_CONTAINS: begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_entries[i] == v)
                        r.found = 1'b1;
            end
            default: shadow_count = 0;
        endcase
        r.count = shadow_count[4:0];
        r.empty = (shadow_count == 0);
        if (shadow_count != 0) begin
            r.min_v       = shadow_entries[0];
            r.max_v       = shadow_entries[shadow_count-1];
            r.extremes_ok = 1'b1;
        end
    endtask

    task automatic add_step(input t_func op, input t_val v, input int reps, input bit typed,
                            input bit found, input bit acc, input int cnt, input bit empty,
                            input t_val min_v, input t_val max_v, input bit ext_ok);
        table_step_t s;
        s.op    = op;
        s.value = v;
        s.reps  = reps;
        s.typed = typed;
        s.want  = '{found, acc, cnt[4:0], empty, min_v, max_v, ext_ok};
        directed_steps = {directed_steps, s};
    endtask

    // offer one item, wait for its transfer, then queue what it should yield
    task automatic send_item(input t_func op, input t_val v, input bit typed,
                             input table_result_t want);
        table_result_t predicted;
        @(negedge i_clk);
        if (!steady) begin
            while ($urandom_range(99) < 19) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_DATA_W-IN_BITS){1'b0}}, v, op};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_table_op(op, v, predicted);
        if (typed)
            predicted = want;
        pending_results = {pending_results, predicted};
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 60;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = steady || ($urandom_range(99) >= 19);
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        table_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, got %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", 32'(want.found), 32'(m_axis_tdata[0]));
                check_field("accepted", 32'(want.accepted), 32'(m_axis_tdata[1]));
                check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[6:2]));
                check_field("is_empty", 32'(want.empty), 32'(m_axis_tdata[7]));
                check_field("min_value", want.min_v, m_axis_tdata[39:8]);
                check_field("max_value", want.max_v, m_axis_tdata[71:40]);
                check_field("extremes_valid", 32'(want.extremes_ok),
                            32'(m_axis_tdata[72]));
            end
        end
    end

    initial begin
        table_step_t   s;
        table_result_t none;
        t_func         op;
        t_val          v;
        t_val          pool [8];
        int            r;
        bit            filling;

        none = '{default: 0};
        pool = '{32'sh0, -32'sh1, 32'sh1, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sh12345678, -32'sd1000, 32'sd42};

        // empty table, extremes, duplicates, full table, clear
        add_step(FUNC_CONTAINS, 32'sh0, 1, 1, 0, 0, 0, 1, 0, 0, 0);
        add_step(FUNC_REMOVE, 32'sd5, 1, 1, 0, 0, 0, 1, 0, 0, 0);
        add_step(FUNC_CLEAR, 32'sh0, 1, 1, 0, 0, 0, 1, 0, 0, 0);
        add_step(FUNC_INSERT, 32'sh7FFFFFFF, 1, 1,
                 0, 1, 1, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
        add_step(FUNC_INSERT, 32'sh80000000, 1, 1,
                 0, 1, 2, 0, 32'sh80000000, 32'sh7FFFFFFF, 1);
        add_step(FUNC_INSERT, 32'sh0, 1, 1, 0, 1, 3, 0, 32'sh80000000, 32'sh7FFFFFFF, 1);
        add_step(FUNC_INSERT, -32'sh1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_INSERT, -32'sh1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_CONTAINS, -32'sh1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_CONTAINS, 32'sh1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_REMOVE, -32'sh1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_REMOVE, -32'sh1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_REMOVE, 32'sh80000000, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_INSERT, 32'sh55555555, 14, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_INSERT, 32'sh1, 1, 1, 0, 0, 16, 0, 32'sh0, 32'sh7FFFFFFF, 1);
        add_step(FUNC_INSERT, 32'sh80000000, 1, 1, 0, 0, 16, 0, 32'sh0, 32'sh7FFFFFFF, 1);
        add_step(FUNC_CONTAINS, 32'sh55555555, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_REMOVE, 32'sh55555555, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_INSERT, 32'shAAAAAAAA, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_REMOVE, 32'sh7FFFFFFF, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_CLEAR, 32'sh7FFFFFFF, 1, 1, 0, 0, 0, 1, 0, 0, 0);
        add_step(FUNC_INSERT, 32'shAAAAAAAA, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_CONTAINS, 32'sh0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(FUNC_REMOVE, 32'sh0, 1, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_steps[k]) begin
            s = directed_steps[k];
            repeat (s.reps)
                send_item(s.op, s.value, s.typed, s.want);
        end

        for (int n = 0; n < 520; n++) begin
            steady = (n >= 200 && n < 300);
            if (n == 120)
                hold_req = 1'b1;
            if (n == 320) begin
                // drain everything before going on
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge i_clk);
            end
            // alternate insert-heavy stretches with mixed traffic
            filling = ((n / 40) % 2 == 0);
            r = $urandom_range(99);
            if (filling)
                op = (r < 70) ? FUNC_INSERT : (r < 80) ? FUNC_REMOVE :
                     (r < 97) ? FUNC_CONTAINS : FUNC_CLEAR;
            else
                op = (r < 35) ? FUNC_INSERT : (r < 60) ? FUNC_REMOVE :
                     (r < 95) ? FUNC_CONTAINS : FUNC_CLEAR;
            v = ($urandom_range(99) < 65) ? pool[$urandom_range(7)] : t_val'($urandom);
            send_item(op, v, 1'b0, none);
        end
        steady = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sorted_set_table_top.f
rtl/core/sst_pkg.sv
rtl/core/sst_cell.sv
rtl/core/sst_chain.sv
rtl/core/sorted_set_table_top.sv
dv/tb.sv
